[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held low.
`define ELS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define ELS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/els_pkg.sv]
// ----------------------------------------------------------------------------
// els_pkg
// Field widths, command and register codes, result type of the embedding
// table engine.
// ----------------------------------------------------------------------------
package els_pkg;

    localparam int W_CMD      = 2;
    localparam int W_TOKEN    = 16;
    localparam int W_POS      = 6;
    localparam int W_WEIGHT   = 16;
    localparam int W_VOCAB    = 11;
    localparam int W_LR       = 16;
    localparam int W_CFG_DATA = 16;
    localparam int W_CFG_IDX  = 1;

    localparam logic [W_CMD-1:0] CMD_LOAD   = 2'd0;
    localparam logic [W_CMD-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [W_CMD-1:0] CMD_UPDATE = 2'd2;

    localparam logic [W_CFG_IDX-1:0] CFG_VOCAB_IN_USE  = 1'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_LEARNING_RATE = 1'd1;

    localparam logic [W_VOCAB-1:0] VOCAB_RESET = 11'd1024;
    localparam logic [W_LR-1:0]    LR_RESET    = 16'd0;

    typedef struct packed {
        logic signed [W_WEIGHT-1:0] weight_out;
        logic [W_POS-1:0]           position;
        logic                       last;
        logic                       error;
    } t_result;

endpackage

[src/els_if.sv]
// ----------------------------------------------------------------------------
// els_if
// Valid/ready channels of the embedding table engine: command items in,
// result items out.
// ----------------------------------------------------------------------------
interface els_in_if import els_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [W_CMD-1:0]           command;
    logic [W_TOKEN-1:0]         token;
    logic [W_POS-1:0]           element;
    logic signed [W_WEIGHT-1:0] value;

    modport source (output valid, output command, output token, output element,
                    output value, input ready);
    modport sink   (input valid, input command, input token, input element,
                    input value, output ready);
endinterface

interface els_out_if import els_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [W_WEIGHT-1:0] weight_out;
    logic [W_POS-1:0]           position;
    logic                       last;
    logic                       error;

    modport source (output valid, output weight_out, output position, output last,
                    output error, input ready);
    modport sink   (input valid, input weight_out, input position, input last,
                    input error, output ready);
endinterface

[src/els_ram.sv]
// ----------------------------------------------------------------------------
// els_ram
// Generic single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module els_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/els_update.sv]
// ----------------------------------------------------------------------------
// els_update
// Gradient step datapath: registered rate-times-gradient product, then
// subtract from the weight, round to Q4.12 and saturate.
// ----------------------------------------------------------------------------
module els_update import els_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [W_LR-1:0]            i_lr,
    input  logic signed [W_WEIGHT-1:0] i_grad,
    input  logic signed [W_WEIGHT-1:0] i_weight,
    output logic signed [W_WEIGHT-1:0] o_weight
);

    localparam int W_PROD = W_LR + 1 + W_WEIGHT;
    localparam int W_SUM  = W_PROD + 1;
    localparam int W_RND  = W_SUM - W_LR;
    localparam logic signed [W_SUM-1:0] HALF = W_SUM'(1) << (W_LR - 1);
    localparam logic signed [W_WEIGHT-1:0] SAT_MAX = {1'b0, {(W_WEIGHT-1){1'b1}}};
    localparam logic signed [W_WEIGHT-1:0] SAT_MIN = {1'b1, {(W_WEIGHT-1){1'b0}}};

    logic signed [W_PROD-1:0] r_prod;
    logic signed [W_SUM-1:0]  w_ext;
    logic signed [W_SUM-1:0]  sum;
    logic signed [W_RND-1:0]  rnd;
    logic [W_RND-W_WEIGHT:0]  top_bits;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= $signed({1'b0, i_lr}) * i_grad;
        end
    end

    always_comb begin
        w_ext    = {{(W_SUM-W_WEIGHT-W_LR){i_weight[W_WEIGHT-1]}}, i_weight, {W_LR{1'b0}}};
        // ties go upward: add a half, then floor by dropping the fraction
        sum      = w_ext - W_SUM'(r_prod) + HALF;
        rnd      = sum[W_SUM-1:W_LR];
        top_bits = rnd[W_RND-1:W_WEIGHT-1];
        if ((&top_bits) || !(|top_bits)) begin
            o_weight = rnd[W_WEIGHT-1:0];
        end else if (rnd[W_RND-1]) begin
            o_weight = SAT_MIN;
        end else begin
            o_weight = SAT_MAX;
        end
    end

endmodule

[src/els_out_queue.sv]
// ----------------------------------------------------------------------------
// els_out_queue
// Two-entry result queue between the table read port and the output channel.
// ----------------------------------------------------------------------------
module els_out_queue import els_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_data,
    input  logic       i_pop,
    output logic       o_valid,
    output t_result    o_data,
    output logic [1:0] o_count
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_result    r_q0;
    t_result    r_q1;

    assign n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            if (r_count == 2'd2) begin
                r_q0 <= r_q1;
            end else if (i_push) begin
                r_q0 <= i_data;
            end
        end else if (i_push && r_count == 2'd0) begin
            r_q0 <= i_data;
        end
        if (i_push && ((r_count == 2'd1 && !i_pop) || (r_count == 2'd2 && i_pop))) begin
            r_q1 <= i_data;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_q0;
    assign o_count = r_count;

endmodule

[src/embedding_lookup_sgd_update.sv]
// ----------------------------------------------------------------------------
// embedding_lookup_sgd_update
// Embedding table engine: element load, row lookup and per-element gradient
// update on a single-port weight memory.
// ----------------------------------------------------------------------------
// The table holds VOCAB_MAX rows of EMBED_DIM Q4.12 words in one single-port
// RAM; load every element before it is looked up or updated, as the memory
// has no reset and no clearing pass. Each command is taken in S_IDLE and then
// owns the RAM port: a load writes in S_LOAD, an update reads in S_UPD_RD and
// writes back in S_UPD_WR, an out-of-range token yields one error result, and
// a lookup reads one row element per cycle while a queue slot is free. A
// two-entry output queue lets reads run at full rate while the consumer keeps
// up; when it stalls, the lookup pauses until a slot frees.
// ----------------------------------------------------------------------------
module embedding_lookup_sgd_update import els_pkg::*; #(
    parameter int VOCAB_MAX = 1024,
    parameter int EMBED_DIM = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [W_CFG_IDX-1:0]  i_cfg_idx,
    input  logic [W_CFG_DATA-1:0] i_cfg_wdata,
    els_in_if.sink                i_in,
    els_out_if.source             o_out
);

    localparam int DEPTH = VOCAB_MAX * EMBED_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(VOCAB_MAX);
    localparam int LW    = W_TOKEN + 1;
    localparam logic [LW-1:0]    VOCAB_MAX_L = LW'(VOCAB_MAX);
    localparam logic [W_POS-1:0] POS_LAST    = W_POS'(EMBED_DIM - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ERR    = 6'b000010,
        S_LOAD   = 6'b000100,
        S_UPD_RD = 6'b001000,
        S_UPD_WR = 6'b010000,
        S_LOOK   = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [AW-1:0]              r_addr, n_addr;
    logic [W_POS-1:0]           r_pos, n_pos;
    logic signed [W_WEIGHT-1:0] r_value;
    logic                       r_pend_v, n_pend_v;
    logic [W_POS-1:0]           r_pend_pos, n_pend_pos;
    logic                       r_pend_last, n_pend_last;
    logic                       r_pend_err, n_pend_err;
    logic [W_VOCAB-1:0]         r_vocab;
    logic [W_LR-1:0]            r_lr;

    logic                       accept;
    logic                       pop;
    logic                       credit_ok;
    logic [LW-1:0]              limit;
    logic                       tok_ok;
    logic                       el_ok;
    logic [AW-1:0]              acc_addr;
    logic                       mem_en, mem_we;
    logic [W_WEIGHT-1:0]        mem_wdata, mem_rdata;
    logic                       upd_load;
    logic signed [W_WEIGHT-1:0] upd_weight;
    t_result                    push_data;
    t_result                    q_data;
    logic                       q_valid;
    logic [1:0]                 q_count;

    assign accept    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign pop       = q_valid && o_out.ready;
    // a slot must be free for the result once its read data lands
    assign credit_ok = ({1'b0, q_count} + {2'b0, r_pend_v} - {2'b0, pop}) < 3'd2;

    assign limit    = ({{(LW-W_VOCAB){1'b0}}, r_vocab} > VOCAB_MAX_L)
                    ? VOCAB_MAX_L : {{(LW-W_VOCAB){1'b0}}, r_vocab};
    assign tok_ok   = {1'b0, i_in.token} < limit;
    assign el_ok    = {1'b0, i_in.element} < (W_POS+1)'(EMBED_DIM);
    assign acc_addr = AW'(i_in.token[TW-1:0] * EMBED_DIM)
                    + ((i_in.command == CMD_LOOKUP) ? AW'(0) : AW'(i_in.element));

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_pos       = r_pos;
        n_pend_v    = 1'b0;
        n_pend_pos  = '0;
        n_pend_last = 1'b0;
        n_pend_err  = 1'b0;
        mem_en      = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = r_value;
        upd_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr = acc_addr;
                    n_pos  = '0;
                    if (!tok_ok) begin
                        n_state = S_ERR;
                    end else begin
                        unique case (i_in.command)
                            CMD_LOOKUP: n_state = S_LOOK;
                            CMD_LOAD:   n_state = el_ok ? S_LOAD : S_IDLE;
                            CMD_UPDATE: n_state = el_ok ? S_UPD_RD : S_IDLE;
                            default:    n_state = S_IDLE;
                        endcase
                    end
                    // the unused command is dropped even for a bad token
                    if (!(i_in.command == CMD_LOAD || i_in.command == CMD_LOOKUP
                          || i_in.command == CMD_UPDATE)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (credit_ok) begin
                    n_pend_v    = 1'b1;
                    n_pend_last = 1'b1;
                    n_pend_err  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_LOAD: begin
                mem_en  = 1'b1;
                mem_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_UPD_RD: begin
                mem_en   = 1'b1;
                upd_load = 1'b1;
                n_state  = S_UPD_WR;
            end
            S_UPD_WR: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_wdata = upd_weight;
                n_state   = S_IDLE;
            end
            S_LOOK: begin
                if (credit_ok) begin
                    mem_en      = 1'b1;
                    n_pend_v    = 1'b1;
                    n_pend_pos  = r_pos;
                    n_pend_last = (r_pos == POS_LAST);
                    n_addr      = r_addr + AW'(1);
                    n_pos       = r_pos + W_POS'(1);
                    if (r_pos == POS_LAST) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_vocab  <= VOCAB_RESET;
            r_lr     <= LR_RESET;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_VOCAB_IN_USE:  r_vocab <= i_cfg_wdata[W_VOCAB-1:0];
                    CFG_LEARNING_RATE: r_lr    <= i_cfg_wdata[W_LR-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_pos       <= n_pos;
        r_pend_pos  <= n_pend_pos;
        r_pend_last <= n_pend_last;
        r_pend_err  <= n_pend_err;
        if (accept) begin
            r_value <= i_in.value;
        end
    end

    els_ram #(
        .WIDTH (W_WEIGHT),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (r_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    els_update u_update (
        .i_clk    (i_clk),
        .i_load   (upd_load),
        .i_lr     (r_lr),
        .i_grad   (r_value),
        .i_weight (mem_rdata),
        .o_weight (upd_weight)
    );

    always_comb begin
        push_data.weight_out = r_pend_err ? '0 : mem_rdata;
        push_data.position   = r_pend_pos;
        push_data.last       = r_pend_last;
        push_data.error      = r_pend_err;
    end

    els_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_pend_v),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_out.valid      = q_valid;
    assign o_out.weight_out = q_data.weight_out;
    assign o_out.position   = q_data.position;
    assign o_out.last       = q_data.last;
    assign o_out.error      = q_data.error;

endmodule

[src/els_checker.sv]
// ----------------------------------------------------------------------------
// els_checker
// Port-level checks on the result channel of the embedding table engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module els_checker import els_pkg::*; #(
    parameter int EMBED_DIM = 16
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic signed [W_WEIGHT-1:0] i_weight_out,
    input logic [W_POS-1:0]           i_position,
    input logic                       i_last,
    input logic                       i_error
);

    localparam logic [W_POS-1:0] POS_LAST = W_POS'(EMBED_DIM - 1);

    `ELS_ASSERT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n |=> !i_out_valid, "result valid straight after reset")
    `ELS_ASSERT(a_error_shape, i_clk, i_rst_n, (i_out_valid && i_error) |-> (i_last && i_weight_out == '0 && i_position == '0), "malformed error result")
    `ELS_ASSERT(a_last_position, i_clk, i_rst_n, (i_out_valid && !i_error && i_last) |-> (i_position == POS_LAST), "lookup run ends at wrong position")
    `ELS_ASSERT(a_stall_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_weight_out) && $stable(i_position) && $stable(i_last) && $stable(i_error)), "stalled result changed")

endmodule

bind embedding_lookup_sgd_update els_checker #(
    .EMBED_DIM (EMBED_DIM)
) u_els_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_weight_out (o_out.weight_out),
    .i_position   (o_out.position),
    .i_last       (o_out.last),
    .i_error      (o_out.error)
);
